// ===== design/tlbs_pkg.sv =====
`timescale 1ns / 1ps

package tlbs_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned ColW  = 12;
  localparam int unsigned RowW  = 12;
  localparam int unsigned ThrW  = 8;
  localparam int unsigned HalfW = 12;
  localparam int unsigned GapW  = 12;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [ThrW-1:0]  ThrReset  = 8'd24;
  localparam logic [HalfW-1:0] HalfReset = 12'd200;
  localparam logic [GapW-1:0]  GapReset  = 12'd100;

  localparam int unsigned DefMaxWidth  = 4096;
  localparam int unsigned DefMaxHeight = 4096;

  // result queue, a power of two
  localparam int unsigned ResDepth = 4;
  localparam int unsigned PtrW     = $clog2(ResDepth);
  localparam int unsigned LvlW     = PtrW + 1;

  typedef enum logic [1:0] {
    RegInkThreshold    = 2'd0,
    RegWindowHalfWidth = 2'd1,
    RegMaxGapRows      = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [RowW-1:0] first_row;
    logic [RowW-1:0] last_row;
    logic            last_of_run;
  } band_t;

endpackage

// ===== design/tlbs_fifo.sv =====
`timescale 1ns / 1ps

module tlbs_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [1:0]                push_n_i,
  input  tlbs_pkg::band_t           push0_i,
  input  tlbs_pkg::band_t           push1_i,
  input  logic                      pop_i,
  output tlbs_pkg::band_t           head_o,
  output logic [tlbs_pkg::LvlW-1:0] level_o
);

  tlbs_pkg::band_t mem_q [tlbs_pkg::ResDepth];

  logic [tlbs_pkg::PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [tlbs_pkg::PtrW-1:0] wr_ptr_nxt;
  logic [tlbs_pkg::LvlW-1:0] level_q, level_d;
  logic                      pop;

  assign pop        = pop_i && (level_q != '0);
  assign wr_ptr_nxt = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + tlbs_pkg::PtrW'(push_n_i);
    rd_ptr_d = rd_ptr_q + tlbs_pkg::PtrW'(pop);
    level_d  = level_q + tlbs_pkg::LvlW'(push_n_i) - tlbs_pkg::LvlW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push1_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign level_o = level_q;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= tlbs_pkg::LvlW'(tlbs_pkg::ResDepth))
    else $error("result queue level above depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tlbs_pkg::PtrW'(wr_ptr_q - rd_ptr_q) == tlbs_pkg::PtrW'(level_q))
    else $error("result queue pointers disagree with level");

endmodule

// ===== design/text_line_band_segmenter.sv =====
`timescale 1ns / 1ps

// Text line band segmenter: takes one grayscale pixel per clock in raster order and
// reports each text-line band as a (first row, last row) word. A pixel word is
// registered on entry and judged from that register; per-row ink flags run
// alongside, so a new pixel is taken every cycle. Band words made by the row-end
// pixel that finishes them pass the input word register and wait in a four-entry
// queue, so output stalls only hold up the input once a row end finds fewer free
// entries than the words it makes (at most two, on the last row of an image).
// Registers sit at APB byte addresses 0x0 ink threshold, 0x4 window half width and
// 0x8 max gap rows; write them only while the block is idle.
module text_line_band_segmenter #(
  parameter int unsigned MAX_WIDTH  = tlbs_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = tlbs_pkg::DefMaxHeight
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlbs_pkg::AddrW-1:0]  paddr,
  input  logic [tlbs_pkg::DataW-1:0]  pwdata,
  output logic [tlbs_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tlbs_pkg::PixW-1:0]   pixel_i,
  input  logic                        row_end_i,
  input  logic                        image_end_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tlbs_pkg::RowW-1:0]   band_first_row_o,
  output logic [tlbs_pkg::RowW-1:0]   band_last_row_o,
  output logic                        last_of_run_o
);

  localparam int unsigned ColCapInt = (MAX_WIDTH > 4096) ? 4095 : MAX_WIDTH - 1;
  localparam int unsigned RowCapInt = (MAX_HEIGHT > 4096) ? 4095 : MAX_HEIGHT - 1;
  localparam logic [tlbs_pkg::ColW-1:0] ColCap = tlbs_pkg::ColW'(ColCapInt);
  localparam logic [tlbs_pkg::RowW-1:0] RowCap = tlbs_pkg::RowW'(RowCapInt);

  typedef struct packed {
    logic [tlbs_pkg::ColW-1:0] col;
    logic [tlbs_pkg::RowW-1:0] row;
    logic                      open;
    logic [tlbs_pkg::RowW-1:0] start;
    logic [tlbs_pkg::RowW-1:0] last_ink;
    logic [tlbs_pkg::ColW-1:0] win_lo;
    logic [tlbs_pkg::ColW-1:0] win_hi;
    logic [tlbs_pkg::ColW-1:0] first_ink;
    logic                      any_ink;
    logic                      win_ink;
  } seg_state_t;

  // configuration registers
  logic [tlbs_pkg::ThrW-1:0]  thr_q;
  logic [tlbs_pkg::HalfW-1:0] half_q;
  logic [tlbs_pkg::GapW-1:0]  gap_q;
  logic                       cfg_wr;
  tlbs_pkg::reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = tlbs_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= tlbs_pkg::ThrReset;
      half_q <= tlbs_pkg::HalfReset;
      gap_q  <= tlbs_pkg::GapReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tlbs_pkg::RegInkThreshold:    thr_q  <= pwdata[tlbs_pkg::ThrW-1:0];
        tlbs_pkg::RegWindowHalfWidth: half_q <= pwdata[tlbs_pkg::HalfW-1:0];
        tlbs_pkg::RegMaxGapRows:      gap_q  <= pwdata[tlbs_pkg::GapW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      tlbs_pkg::RegInkThreshold:    prdata = tlbs_pkg::DataW'(thr_q);
      tlbs_pkg::RegWindowHalfWidth: prdata = tlbs_pkg::DataW'(half_q);
      tlbs_pkg::RegMaxGapRows:      prdata = tlbs_pkg::DataW'(gap_q);
      default:                      prdata = '0;
    endcase
  end

  // input word register
  logic                      in_valid_q, in_valid_d;
  logic [tlbs_pkg::PixW-1:0] pix_q;
  logic                      row_end_q, img_end_q;
  logic                      fire;

  assign in_ready_o = !in_valid_q || fire;
  assign in_valid_d = (in_valid_i && in_ready_o) || (in_valid_q && !fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pix_q     <= pixel_i;
      row_end_q <= row_end_i;
      img_end_q <= image_end_i;
    end
  end

  // row judgment
  seg_state_t                st_q, st_d;
  logic                      ink, in_win, any_n, win_ink_n, row_done;
  logic [tlbs_pkg::ColW-1:0] first_n, lo, hi;
  logic [tlbs_pkg::ColW:0]   hi_sum;
  logic [tlbs_pkg::RowW-1:0] gap, row_prev;
  logic                      close, still_open, open_new, emit_end;
  logic [1:0]                push_n;
  tlbs_pkg::band_t           res0, res1, head;
  logic [tlbs_pkg::LvlW-1:0] level, free;

  always_comb begin
    ink       = pix_q > thr_q;
    in_win    = (st_q.col >= st_q.win_lo) && (st_q.col <= st_q.win_hi);
    any_n     = st_q.any_ink || ink;
    first_n   = st_q.any_ink ? st_q.first_ink : st_q.col;
    win_ink_n = st_q.win_ink || (ink && st_q.open && in_win);
    row_done  = row_end_q || img_end_q;

    gap      = st_q.row - st_q.last_ink;
    row_prev = st_q.row - 1'b1;

    close      = row_done && st_q.open && !win_ink_n && (!any_n || (gap > gap_q));
    still_open = st_q.open && !close;
    open_new   = row_done && !still_open && any_n;
    emit_end   = img_end_q && (still_open || open_new);

    lo     = (first_n >= half_q) ? first_n - half_q : '0;
    hi_sum = {1'b0, first_n} + {1'b0, half_q};
    hi     = (hi_sum > {1'b0, st_q.col}) ? st_q.col : hi_sum[tlbs_pkg::ColW-1:0];

    // closed band first, then the band left open at image end
    res0 = '0;
    res1 = '0;
    if (close) begin
      res0.first_row   = st_q.start;
      res0.last_row    = row_prev;
      res0.last_of_run = !emit_end;
      res1.first_row   = st_q.row;
      res1.last_row    = st_q.row;
      res1.last_of_run = 1'b1;
    end else begin
      res0.first_row   = open_new ? st_q.row : st_q.start;
      res0.last_row    = st_q.row;
      res0.last_of_run = 1'b1;
    end
    push_n = {1'b0, close} + {1'b0, emit_end};

    free = tlbs_pkg::LvlW'(tlbs_pkg::ResDepth) - level;
    fire = in_valid_q && (tlbs_pkg::LvlW'(push_n) <= free);

    st_d = st_q;
    if (fire) begin
      if (!row_done) begin
        st_d.col       = (st_q.col < ColCap) ? st_q.col + 1'b1 : ColCap;
        st_d.any_ink   = any_n;
        st_d.first_ink = first_n;
        st_d.win_ink   = win_ink_n;
      end else begin
        if (st_q.open && win_ink_n) begin
          st_d.last_ink = st_q.row;
        end
        if (close) begin
          st_d.open = 1'b0;
        end
        if (open_new) begin
          st_d.start    = st_q.row;
          st_d.last_ink = st_q.row;
          st_d.win_lo   = lo;
          st_d.win_hi   = hi;
          st_d.open     = 1'b1;
        end
        if (img_end_q) begin
          st_d = '0;
        end else begin
          st_d.row       = (st_q.row < RowCap) ? st_q.row + 1'b1 : RowCap;
          st_d.col       = '0;
          st_d.first_ink = '0;
          st_d.any_ink   = 1'b0;
          st_d.win_ink   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  tlbs_fifo u_res_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (fire ? push_n : 2'd0),
    .push0_i  (res0),
    .push1_i  (res1),
    .pop_i    (out_ready_i),
    .head_o   (head),
    .level_o  (level)
  );

  assign out_valid_o      = level != '0;
  assign band_first_row_o = head.first_row;
  assign band_last_row_o  = head.last_row;
  assign last_of_run_o    = head.last_of_run;

  a_img_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && img_end_q |=> !st_q.open && (st_q.row == '0) && (st_q.col == '0))
    else $error("state not cleared after image end");

  a_pair_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> level >= tlbs_pkg::LvlW'(2))
    else $error("first word of a pair without its partner queued");

  a_row_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !row_end_q && !img_end_q |=> $stable(st_q.row) && $stable(st_q.open))
    else $error("row or band state moved inside a row");

  a_no_word_mid_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !row_end_q && !img_end_q |-> push_n == 2'd0)
    else $error("band word made by a pixel that ends no row");

endmodule

// ===== verif/text_line_band_segmenter_checker.sv =====
`timescale 1ns / 1ps

module text_line_band_segmenter_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [tlbs_pkg::AddrW-1:0]  paddr,
  input  logic [tlbs_pkg::DataW-1:0]  pwdata,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [tlbs_pkg::PixW-1:0]   pixel_i,
  input  logic                        row_end_i,
  input  logic                        image_end_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [tlbs_pkg::RowW-1:0]   band_first_row_i,
  input  logic [tlbs_pkg::RowW-1:0]   band_last_row_i,
  input  logic                        last_of_run_i,
  output int                          band_errors_o,
  output int                          bands_pending_o
);

  localparam logic [11:0] IndexCap = 12'hfff;

  logic [tlbs_pkg::ThrW-1:0]  ink_thr;
  logic [tlbs_pkg::HalfW-1:0] half_width;
  logic [tlbs_pkg::GapW-1:0]  gap_limit;

  logic [11:0] col_at;
  logic [11:0] row_at;
  logic [11:0] band_top;
  logic [11:0] last_hit_row;
  logic [11:0] win_lo;
  logic [11:0] win_hi;
  logic [11:0] first_ink_col;
  logic        band_live;
  logic        row_ink;
  logic        row_win_ink;

  tlbs_pkg::band_t band_q[$];

  task automatic report_mismatch(input string msg);
    $display("band mismatch: %s", msg);
    band_errors_o++;
  endtask

  task automatic clear_scan();
    col_at        = '0;
    row_at        = '0;
    band_live     = 1'b0;
    band_top      = '0;
    last_hit_row  = '0;
    win_lo        = '0;
    win_hi        = '0;
    first_ink_col = '0;
    row_ink       = 1'b0;
    row_win_ink   = 1'b0;
  endtask

  task automatic push_band(input logic [11:0] first, input logic [11:0] last);
    tlbs_pkg::band_t b;
    b.first_row   = first;
    b.last_row    = last;
    b.last_of_run = 1'b0;
    band_q.push_back(b);
  endtask

  task automatic predict_bands(input logic [7:0] pix, input logic row_end,
                               input logic img_end);
    logic [11:0] col;
    logic [11:0] row;
    logic [11:0] row_gap;
    logic [11:0] closed_last;
    logic [12:0] hi_sum;
    int          base;
    col  = col_at;
    row  = row_at;
    base = band_q.size();
    if (pix > ink_thr) begin
      if (!row_ink) begin
        first_ink_col = col;
        row_ink       = 1'b1;
      end
      if (band_live && col >= win_lo && col <= win_hi) row_win_ink = 1'b1;
    end
    if (!(row_end || img_end)) begin
      if (col != IndexCap) col_at = col + 12'd1;
      return;
    end
    // judge the finished row
    if (band_live) begin
      row_gap     = row - last_hit_row;
      closed_last = row - 12'd1;
      if (row_win_ink) begin
        last_hit_row = row;
      end else if (!row_ink || row_gap > gap_limit) begin
        push_band(band_top, closed_last);
        band_live = 1'b0;
      end
    end
    if (!band_live && row_ink) begin
      win_lo       = (first_ink_col >= half_width) ? first_ink_col - half_width : '0;
      hi_sum       = {1'b0, first_ink_col} + {1'b0, half_width};
      win_hi       = (hi_sum > {1'b0, col}) ? col : hi_sum[11:0];
      band_top     = row;
      last_hit_row = row;
      band_live    = 1'b1;
    end
    if (img_end) begin
      if (band_live) push_band(band_top, row);
      clear_scan();
    end else begin
      if (row != IndexCap) row_at = row + 12'd1;
      col_at        = '0;
      first_ink_col = '0;
      row_ink       = 1'b0;
      row_win_ink   = 1'b0;
    end
    if (band_q.size() > base) band_q[band_q.size() - 1].last_of_run = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tlbs_pkg::band_t want;
    if (!rst_ni) begin
      ink_thr         = tlbs_pkg::ThrReset;
      half_width      = tlbs_pkg::HalfReset;
      gap_limit       = tlbs_pkg::GapReset;
      clear_scan();
      band_q.delete();
      band_errors_o   = 0;
      bands_pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (tlbs_pkg::reg_idx_e'(paddr[3:2]))
          tlbs_pkg::RegInkThreshold:    ink_thr    = pwdata[tlbs_pkg::ThrW-1:0];
          tlbs_pkg::RegWindowHalfWidth: half_width = pwdata[tlbs_pkg::HalfW-1:0];
          tlbs_pkg::RegMaxGapRows:      gap_limit  = pwdata[tlbs_pkg::GapW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_bands(pixel_i, row_end_i, image_end_i);
      if (out_valid_i && out_ready_i) begin
        if (band_q.size() == 0) begin
          report_mismatch($sformatf("unexpected band %0d..%0d", band_first_row_i,
                                    band_last_row_i));
        end else begin
          want = band_q.pop_front();
          if (band_first_row_i !== want.first_row)
            report_mismatch($sformatf("first row got %0d want %0d", band_first_row_i,
                                      want.first_row));
          if (band_last_row_i !== want.last_row)
            report_mismatch($sformatf("last row got %0d want %0d", band_last_row_i,
                                      want.last_row));
          if (last_of_run_i !== want.last_of_run)
            report_mismatch($sformatf("last of run got %0b want %0b", last_of_run_i,
                                      want.last_of_run));
        end
      end
      bands_pending_o <= band_q.size();
    end
  end

endmodule

// ===== verif/text_line_band_segmenter_test.sv =====
`timescale 1ns / 1ps

module text_line_band_segmenter_test;

  localparam int unsigned CycleLimit = 800000;

  typedef struct packed {
    logic [tlbs_pkg::PixW-1:0] pix;
    logic                      row_end;
    logic                      img_end;
  } pixel_word_t;

  logic                       clk;
  logic                       rst_n;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [tlbs_pkg::AddrW-1:0] paddr;
  logic [tlbs_pkg::DataW-1:0] pwdata;
  logic [tlbs_pkg::DataW-1:0] prdata;
  logic                       pready;
  logic                       in_valid;
  logic                       in_ready;
  logic [tlbs_pkg::PixW-1:0]  pixel;
  logic                       row_end;
  logic                       image_end;
  logic                       out_valid;
  logic                       out_ready;
  logic [tlbs_pkg::RowW-1:0]  band_first_row;
  logic [tlbs_pkg::RowW-1:0]  band_last_row;
  logic                       last_of_run;

  int                         band_errors;
  int                         bands_pending;
  int                         cycle_count = 0;
  int                         burst_left;
  int                         gap_left;
  bit                         hold_request = 1'b0;
  logic [tlbs_pkg::ThrW-1:0]  cur_thr = tlbs_pkg::ThrReset;
  pixel_word_t                pixel_q[$];

  text_line_band_segmenter u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .pixel_i          (pixel),
    .row_end_i        (row_end),
    .image_end_i      (image_end),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .band_first_row_o (band_first_row),
    .band_last_row_o  (band_last_row),
    .last_of_run_o    (last_of_run)
  );

  text_line_band_segmenter_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .pixel_i          (pixel),
    .row_end_i        (row_end),
    .image_end_i      (image_end),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .band_first_row_i (band_first_row),
    .band_last_row_i  (band_last_row),
    .last_of_run_i    (last_of_run),
    .band_errors_o    (band_errors),
    .bands_pending_o  (bands_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // pixel sender: bursts of words with random gaps between them
  always @(posedge clk or negedge rst_n) begin
    pixel_word_t word;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      pixel      <= '0;
      row_end    <= 1'b0;
      image_end  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0 || pixel_q.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        word      = pixel_q.pop_front();
        in_valid  <= 1'b1;
        pixel     <= word.pix;
        row_end   <= word.row_end;
        image_end <= word.img_end;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // band receiver: random stall pattern, plus one long hold on request
  initial begin : receiver
    int mode;
    int span;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (600) begin
          @(posedge clk);
          out_ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 9);
      span = $urandom_range(1, 30);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0, 1, 2, 3, 4: out_ready <= 1'b1;
          5, 6, 7:       out_ready <= ($urandom_range(0, 3) != 0);
          8:             out_ready <= $urandom_range(0, 1);
          default:       out_ready <= 1'b0;
        endcase
      end
    end
  end

  function automatic logic [tlbs_pkg::PixW-1:0] pick_pixel(input bit ink);
    if (ink && cur_thr != 8'hff)
      return tlbs_pkg::PixW'($urandom_range(cur_thr + 1, 255));
    return tlbs_pkg::PixW'($urandom_range(0, cur_thr));
  endfunction

  task automatic push_word(input logic [tlbs_pkg::PixW-1:0] pix, input logic re,
                           input logic ie);
    pixel_word_t word;
    word.pix     = pix;
    word.row_end = re;
    word.img_end = ie;
    pixel_q.push_back(word);
  endtask

  task automatic write_reg(input tlbs_pkg::reg_idx_e idx,
                           input logic [tlbs_pkg::DataW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tlbs_pkg::AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [tlbs_pkg::ThrW-1:0] thr,
                            input logic [tlbs_pkg::HalfW-1:0] half,
                            input logic [tlbs_pkg::GapW-1:0] gap);
    write_reg(tlbs_pkg::RegInkThreshold, tlbs_pkg::DataW'(thr));
    write_reg(tlbs_pkg::RegWindowHalfWidth, tlbs_pkg::DataW'(half));
    write_reg(tlbs_pkg::RegMaxGapRows, tlbs_pkg::DataW'(gap));
    cur_thr = thr;
  endtask

  // wait until every word went in and every band came out
  task automatic drain();
    while (pixel_q.size() != 0 || in_valid) @(posedge clk);
    while (bands_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // one image of rows that mostly hold ink near a drifting column
  task automatic queue_image(input int room);
    int w;
    int h;
    int center;
    int kind;
    int col;
    int row;
    bit ink;
    bit last;
    logic [tlbs_pkg::PixW-1:0] value;
    w = $urandom_range(2, 16);
    case ($urandom_range(0, 19))
      0:       w = 1;
      1, 2:    w = $urandom_range(17, 80);
      default: ;
    endcase
    h      = $urandom_range(1, 24);
    // keep the image within the words still wanted
    if (w * h > room) h = (room > w) ? room / w : 1;
    center = $urandom_range(0, w - 1);
    for (row = 0; row < h; row++) begin
      if ($urandom_range(0, 7) == 0) center = $urandom_range(0, w - 1);
      kind = $urandom_range(0, 9);
      for (col = 0; col < w; col++) begin
        case (kind)
          0, 1:          ink = 1'b0;
          2, 3, 4, 5, 6: ink = (col >= center - 1 && col <= center + 1) &&
                               ($urandom_range(0, 3) != 0);
          7, 8:          ink = (col > center + 3 || col + 3 < center) &&
                               ($urandom_range(0, 2) == 0);
          default:       ink = $urandom_range(0, 1);
        endcase
        value = (kind == 9) ? tlbs_pkg::PixW'($urandom_range(0, 255)) : pick_pixel(ink);
        last  = (row == h - 1) && (col == w - 1);
        push_word(value, (col == w - 1) && (!last || $urandom_range(0, 1) == 1), last);
      end
    end
  endtask

  task automatic queue_random(input int budget);
    while (pixel_q.size() < budget) queue_image(budget - pixel_q.size());
  endtask

  initial begin : stimulus
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_n   <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // threshold edge: 24 is blank, 25 is ink; blank row closes, last row reopens
    push_word(8'd24, 1'b0, 1'b0);
    push_word(8'd25, 1'b1, 1'b0);
    push_word(8'd0, 1'b0, 1'b0);
    push_word(8'd0, 1'b1, 1'b0);
    push_word(8'd255, 1'b0, 1'b0);
    push_word(8'd0, 1'b1, 1'b1);
    // single ink pixel image, end flag without row flag
    push_word(8'd25, 1'b0, 1'b1);
    drain();

    set_config(8'd24, 12'd0, 12'd0);
    // out-of-window ink on the last row closes one band and opens another
    push_word(8'd25, 1'b0, 1'b0);
    push_word(8'd0, 1'b0, 1'b0);
    push_word(8'd0, 1'b1, 1'b0);
    push_word(8'd0, 1'b0, 1'b0);
    push_word(8'd0, 1'b0, 1'b0);
    push_word(8'd200, 1'b1, 1'b1);
    // window ink holds the band, outside ink reopens, blank last row closes
    push_word(8'd0, 1'b0, 1'b0);
    push_word(8'd30, 1'b0, 1'b0);
    push_word(8'd0, 1'b1, 1'b0);
    push_word(8'd0, 1'b0, 1'b0);
    push_word(8'd40, 1'b0, 1'b0);
    push_word(8'd0, 1'b1, 1'b0);
    push_word(8'd0, 1'b0, 1'b0);
    push_word(8'd0, 1'b0, 1'b0);
    push_word(8'd90, 1'b1, 1'b0);
    push_word(8'd0, 1'b0, 1'b0);
    push_word(8'd0, 1'b0, 1'b0);
    push_word(8'd0, 1'b1, 1'b1);
    drain();

    queue_random(260);
    drain();
    set_config(tlbs_pkg::ThrReset, tlbs_pkg::HalfReset, tlbs_pkg::GapReset);
    queue_random(260);
    drain();
    set_config(8'd0, 12'd2, 12'd1);
    hold_request = 1'b1;
    queue_random(260);
    drain();
    set_config(8'd128, 12'd4095, 12'd4095);
    queue_random(260);
    drain();
    set_config(8'd255, 12'd3, 12'd2);
    queue_random(80);
    drain();
    set_config(8'd90, 12'd1, 12'd3);
    queue_random(220);
    drain();
    set_config(8'd200, 12'd5, 12'd0);
    queue_random(220);
    drain();

    repeat (20) @(posedge clk);
    if (band_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tlbs_pkg.sv
design/tlbs_fifo.sv
design/text_line_band_segmenter.sv
verif/text_line_band_segmenter_checker.sv
verif/text_line_band_segmenter_test.sv
